// ===== rtl/nfmt_pkg.sv =====
// Shared types, character codes and helper functions for the number formatter.
// Used by nfmt_dabble, nfmt_emit and format_string_number_formatter_top.
package nfmt_pkg;

  localparam int CharW     = 8;
  localparam int ArgFieldW = 16;
  localparam int DigitW    = 4;

  localparam logic [CharW-1:0] ChPercent = 8'h25;
  localparam logic [CharW-1:0] ChConvC   = 8'h63;
  localparam logic [CharW-1:0] ChConvD   = 8'h64;
  localparam logic [CharW-1:0] ChConvX   = 8'h78;
  localparam logic [CharW-1:0] ChZero    = 8'h30;
  localparam logic [CharW-1:0] ChUpperA  = 8'h41;

  localparam logic [DigitW-1:0] Radix10     = 4'd10;
  localparam logic [DigitW-1:0] DabbleLimit = 4'd5;
  localparam logic [DigitW-1:0] DabbleAdd   = 4'd3;

  typedef struct packed {
    logic [CharW-1:0]     fmt_char;
    logic [ArgFieldW-1:0] arg_value;
  } in_req_t;

  typedef struct packed {
    logic [CharW-1:0] out_char;
    logic             last;
  } out_req_t;

  // Digit offered by the emitter to the top level.
  typedef struct packed {
    logic             valid;
    logic [CharW-1:0] chr;
    logic             last;
  } digit_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHAR,
    ST_CONV
  } fmt_state_e;

  // ASCII for one hex or decimal digit, uppercase letters.
  function automatic logic [CharW-1:0] digit_char(logic [DigitW-1:0] d);
    if (d < Radix10) begin
      return ChZero + CharW'(d);
    end
    return ChUpperA + CharW'(d - Radix10);
  endfunction

  // Number of decimal digits needed for the largest w-bit unsigned value.
  function automatic int dec_digits(int w);
    longint lim;
    longint pw;
    int     n;
    lim = longint'(1) << w;
    pw  = 1;
    n   = 0;
    for (int i = 0; i < 12; i++) begin
      if (pw < lim) begin
        pw = pw * 10;
        n  = n + 1;
      end
    end
    return n;
  endfunction

endpackage

// ===== rtl/nfmt_dabble.sv =====
// Bit-serial binary to BCD converter (shift and add-three), one bit per cycle.
// Depends on nfmt_pkg for the digit width and correction constants.
module nfmt_dabble #(
  parameter int VAL_W   = 16,
  parameter int NUM_DIG = 5
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic [VAL_W-1:0]                       value_i,
  output logic                                   done_o,
  output logic [NUM_DIG*nfmt_pkg::DigitW-1:0]    bcd_o
);

  localparam int BcdW = NUM_DIG * nfmt_pkg::DigitW;
  localparam int CntW = $clog2(VAL_W + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [VAL_W-1:0] val_q;
  logic [BcdW-1:0]  bcd_q;
  logic [BcdW-1:0]  adj;
  logic             final_bit;

  assign final_bit = (cnt_q == CntW'(1));

  // Each BCD digit of five or more gets three added before the shift.
  always_comb begin
    adj = bcd_q;
    for (int i = 0; i < NUM_DIG; i++) begin
      if (bcd_q[i*nfmt_pkg::DigitW +: nfmt_pkg::DigitW] >= nfmt_pkg::DabbleLimit) begin
        adj[i*nfmt_pkg::DigitW +: nfmt_pkg::DigitW] =
          bcd_q[i*nfmt_pkg::DigitW +: nfmt_pkg::DigitW] + nfmt_pkg::DabbleAdd;
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(VAL_W);
    end else if (busy_q) begin
      cnt_d  = cnt_q - CntW'(1);
      done_d = final_bit;
      busy_d = !final_bit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q <= value_i;
      bcd_q <= '0;
    end else if (busy_q) begin
      val_q <= val_q << 1;
      bcd_q <= {adj[BcdW-2:0], val_q[VAL_W-1]};
    end
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

// ===== rtl/nfmt_emit.sv =====
// Digit shift register that emits one ASCII digit per cycle while take_i is high, most
// significant first, skipping leading zeros. Depends on nfmt_pkg for digit_t and digit_char.
module nfmt_emit #(
  parameter int NUM_DIG = 5
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  logic [NUM_DIG*nfmt_pkg::DigitW-1:0] digits_i,
  input  logic                                take_i,
  output nfmt_pkg::digit_t                    digit_o
);

  localparam int BcdW = NUM_DIG * nfmt_pkg::DigitW;
  localparam int PosW = $clog2(NUM_DIG + 1);

  logic                          active_q, active_d;
  logic                          started_q, started_d;
  logic [PosW-1:0]               pos_q, pos_d;
  logic [BcdW-1:0]               dig_q;
  logic [nfmt_pkg::DigitW-1:0]   top_dig;
  logic                          final_pos;
  logic                          skip;
  logic                          sent;
  logic                          advance;

  assign top_dig   = dig_q[BcdW-1 -: nfmt_pkg::DigitW];
  assign final_pos = (pos_q == PosW'(1));
  // The least significant digit is always sent, so zero prints as one '0'.
  assign skip      = active_q && !started_q && (top_dig == '0) && !final_pos;

  assign digit_o.valid = active_q && !skip;
  assign digit_o.chr   = nfmt_pkg::digit_char(top_dig);
  assign digit_o.last  = final_pos;

  assign sent    = digit_o.valid && take_i;
  assign advance = skip || sent;

  always_comb begin
    active_d  = active_q;
    started_d = started_q;
    pos_d     = pos_q;
    if (load_i) begin
      active_d  = 1'b1;
      started_d = 1'b0;
      pos_d     = PosW'(NUM_DIG);
    end else if (advance) begin
      pos_d = pos_q - PosW'(1);
      if (sent) begin
        started_d = 1'b1;
        if (final_pos) begin
          active_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      started_q <= 1'b0;
      pos_q     <= '0;
    end else begin
      active_q  <= active_d;
      started_q <= started_d;
      pos_q     <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      dig_q <= digits_i;
    end else if (advance) begin
      dig_q <= dig_q << nfmt_pkg::DigitW;
    end
  end

endmodule

// ===== rtl/format_string_number_formatter_top.sv =====
// A plain character or %c result is loaded into the output register if that register is free;
// else it waits in char_q (ST_CHAR). A '%' or an unknown conversion gives no result.
// %x: the argument loads as digits; each position is then sent or, if a leading zero, skipped.
// %d: bit-serial BCD conversion of the ARG_WIDTH-bit (at most 16) argument, then as %x.
// Throughput: one plain character per unstalled cycle; conversions hold off input until their last digit.
// Reset (async, active low) clears the pending-percent flag, the sequencer and all valid flags.
module format_string_number_formatter_top #(
  parameter int ARG_WIDTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  nfmt_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output nfmt_pkg::out_req_t out_req_o
);

  // The argument field has 16 bits, so a wider ARG_WIDTH adds nothing.
  localparam int ValW   = (ARG_WIDTH < nfmt_pkg::ArgFieldW) ? ARG_WIDTH : nfmt_pkg::ArgFieldW;
  // Decimal needs at least as many digit positions as hex, so one register serves both.
  localparam int NumDig = nfmt_pkg::dec_digits(ValW);
  localparam int BcdW   = NumDig * nfmt_pkg::DigitW;

  nfmt_pkg::fmt_state_e state_q, state_d;
  logic                 percent_seen_q, percent_seen_d;
  logic [nfmt_pkg::CharW-1:0] char_q, char_d;

  logic                 out_valid_q, out_valid_d;
  nfmt_pkg::out_req_t   out_q;
  nfmt_pkg::out_req_t   out_data;
  logic                 out_load;
  logic                 out_free;

  logic                 accept;
  logic [ValW-1:0]      arg_val;
  logic                 have_char;
  logic [nfmt_pkg::CharW-1:0] emit_char;

  logic                 dab_start;
  logic                 dab_done;
  logic [BcdW-1:0]      dab_bcd;
  logic                 hex_load;
  logic                 em_load;
  logic [BcdW-1:0]      em_digits;
  logic                 em_take;
  nfmt_pkg::digit_t     em_digit;

  // The input is taken only while the sequencer is idle; the output register
  // decouples the two sides so a waiting result does not block plain requests
  // that produce nothing.
  assign in_stall_o = (state_q != nfmt_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign arg_val    = in_req_i.arg_value[ValW-1:0];

  // The output register can take a new result when empty or being drained.
  assign out_free   = !out_valid_q || !out_stall_i;

  nfmt_dabble #(
    .VAL_W  (ValW),
    .NUM_DIG(NumDig)
  ) u_dabble (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(dab_start),
    .value_i(arg_val),
    .done_o (dab_done),
    .bcd_o  (dab_bcd)
  );

  // Hex digits load straight from the argument; decimal ones come from the
  // converter once it finishes.
  assign em_load   = dab_done || hex_load;
  assign em_digits = hex_load ? BcdW'(arg_val) : dab_bcd;

  nfmt_emit #(
    .NUM_DIG(NumDig)
  ) u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (em_load),
    .digits_i(em_digits),
    .take_i  (em_take),
    .digit_o (em_digit)
  );

  // Sequencer: decodes each request, tracks a pending '%', and steers either a
  // single character or the digit stream into the output register.
  always_comb begin
    state_d        = state_q;
    percent_seen_d = percent_seen_q;
    char_d         = char_q;
    out_load       = 1'b0;
    out_data       = '0;
    have_char      = 1'b0;
    emit_char      = in_req_i.fmt_char;
    dab_start      = 1'b0;
    hex_load       = 1'b0;
    em_take        = 1'b0;
    case (state_q)
      nfmt_pkg::ST_IDLE: begin
        if (accept) begin
          if (!percent_seen_q) begin
            if (in_req_i.fmt_char == nfmt_pkg::ChPercent) begin
              percent_seen_d = 1'b1;
            end else begin
              have_char = 1'b1;
            end
          end else begin
            percent_seen_d = 1'b0;
            case (in_req_i.fmt_char)
              nfmt_pkg::ChConvC: begin
                have_char = 1'b1;
                emit_char = in_req_i.arg_value[nfmt_pkg::CharW-1:0];
              end
              nfmt_pkg::ChConvD: begin
                dab_start = 1'b1;
                state_d   = nfmt_pkg::ST_CONV;
              end
              nfmt_pkg::ChConvX: begin
                hex_load = 1'b1;
                state_d  = nfmt_pkg::ST_CONV;
              end
              default: begin
                // Unknown conversion or a doubled percent: nothing is sent.
              end
            endcase
          end
          if (have_char) begin
            if (out_free) begin
              out_load          = 1'b1;
              out_data.out_char = emit_char;
              out_data.last     = 1'b1;
            end else begin
              char_d  = emit_char;
              state_d = nfmt_pkg::ST_CHAR;
            end
          end
        end
      end
      nfmt_pkg::ST_CHAR: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_data.out_char = char_q;
          out_data.last     = 1'b1;
          state_d           = nfmt_pkg::ST_IDLE;
        end
      end
      nfmt_pkg::ST_CONV: begin
        if (em_digit.valid && out_free) begin
          em_take           = 1'b1;
          out_load          = 1'b1;
          out_data.out_char = em_digit.chr;
          out_data.last     = em_digit.last;
          if (em_digit.last) begin
            state_d = nfmt_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = nfmt_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= nfmt_pkg::ST_IDLE;
      percent_seen_q <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      percent_seen_q <= percent_seen_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    if (out_load) begin
      out_q <= out_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  // A '%' taken with nothing pending arms a conversion.
  a_percent_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !percent_seen_q && (in_req_i.fmt_char == nfmt_pkg::ChPercent)
      |=> percent_seen_q)
    else $error("percent did not arm a conversion");

  // Any request taken while a conversion is pending consumes it.
  a_percent_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && percent_seen_q |=> !percent_seen_q)
    else $error("pending conversion not cleared");

  // Digits are only offered while the sequencer is in a conversion.
  a_digit_in_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    em_digit.valid |-> (state_q == nfmt_pkg::ST_CONV))
    else $error("digit offered outside a conversion");

  // The BCD converter only finishes during a decimal conversion.
  a_dabble_in_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dab_done |-> (state_q == nfmt_pkg::ST_CONV))
    else $error("BCD conversion finished outside a conversion");

endmodule

// ===== tb/format_string_number_formatter_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the number formatter: watches both request channels, predicts
// the output characters and compares them. Depends on nfmt_pkg for the types.
module format_string_number_formatter_checker
  import nfmt_pkg::*;
#(
  parameter int ARG_WIDTH = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_stall_i,
  input  in_req_t  in_req_i,
  input  logic     out_valid_i,
  input  logic     out_stall_i,
  input  out_req_t out_req_i,
  output int       mismatches_o,
  output int       pending_o,
  output int       checked_o
);

  localparam logic [31:0] DecBase   = 32'd10;
  localparam logic [31:0] HexBase   = 32'd16;
  localparam int          MaxDigits = 12;

  logic     conv_armed;
  out_req_t expected_chars[$];
  out_req_t want;

  // Push the digits of a value, most significant first; the last one is marked.
  function automatic void queue_number(logic [31:0] value, logic [31:0] base);
    logic [CharW-1:0] digits[MaxDigits];
    logic [31:0]      d;
    int               n;
    n = 0;
    do begin
      d = value % base;
      digits[n] = (d < DecBase) ? ChZero + CharW'(d) : ChUpperA + CharW'(d - DecBase);
      value = value / base;
      n++;
    end while (value != 0 && n < MaxDigits);
    for (int i = n - 1; i >= 0; i--) begin
      expected_chars.push_back('{out_char: digits[i], last: (i == 0)});
    end
  endfunction

  function automatic void format_request(in_req_t req);
    logic [31:0] arg;
    arg = 32'(req.arg_value);
    if (ARG_WIDTH < 32) begin
      arg = arg & ((32'd1 << ARG_WIDTH) - 32'd1);
    end
    if (!conv_armed) begin
      if (req.fmt_char == ChPercent) begin
        conv_armed = 1'b1;
      end else begin
        expected_chars.push_back('{out_char: req.fmt_char, last: 1'b1});
      end
    end else begin
      conv_armed = 1'b0;
      case (req.fmt_char)
        ChConvC: expected_chars.push_back('{out_char: arg[7:0], last: 1'b1});
        ChConvD: queue_number(arg, DecBase);
        ChConvX: queue_number(arg, HexBase);
        default: ;
      endcase
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conv_armed = 1'b0;
      expected_chars.delete();
      mismatches_o = 0;
      checked_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        format_request(in_req_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected result: out_char %h last %b", out_req_i.out_char, out_req_i.last);
          mismatches_o++;
        end else begin
          want = expected_chars.pop_front();
          if (out_req_i.out_char !== want.out_char) begin
            $error("out_char: expected %h, got %h", want.out_char, out_req_i.out_char);
            mismatches_o++;
          end
          if (out_req_i.last !== want.last) begin
            $error("last: expected %b, got %b", want.last, out_req_i.last);
            mismatches_o++;
          end
          checked_o++;
        end
      end
    end
    pending_o = expected_chars.size();
  end

endmodule

// ===== tb/format_string_number_formatter_top_test.sv =====
`timescale 1ns / 1ps
// Top of the number formatter testbench: clock, reset, request stimulus and verdict.
// Depends on nfmt_pkg, the formatter RTL and format_string_number_formatter_checker.
module format_string_number_formatter_top_test;
  import nfmt_pkg::*;

  localparam int CycleLimit  = 300000;
  localparam int TailCycles  = 60;
  // Requests in the random part; a conversion counts as its two requests.
  localparam int RandomItems = 300;

  // Receiver behavior, chosen afresh for every stretch of cycles.
  typedef enum int {
    StallNone,
    StallLight,
    StallHeavy,
    StallPeriodic
  } stall_mode_e;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  in_req_t  in_req_i    = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  out_req_t out_req_o;

  int mismatches;
  int pending;
  int checked;

  // Stimulus bookkeeping. A burst is a run of requests offered back to back.
  int burst_left = 0;
  int n_plain    = 0;
  int n_conv     = 0;
  int n_noise    = 0;
  int n_sent     = 0;

  stall_mode_e stall_mode = StallNone;
  int          stall_span = 0;
  int          stall_tick = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  format_string_number_formatter_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

  format_string_number_formatter_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_req_i     (in_req_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_req_i    (out_req_o),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // The receiver stalls on its own schedule: long stretches without any stall,
  // light and heavy random stalling, and a fixed periodic pattern driven by stall_tick.
  always @(posedge clk_i) begin
    if (stall_span == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_span = $urandom_range(8, 80);
    end
    stall_span--;
    stall_tick++;
    case (stall_mode)
      StallNone:  out_stall_i <= 1'b0;
      StallLight: out_stall_i <= ($urandom_range(0, 3) == 0);
      StallHeavy: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:    out_stall_i <= (stall_tick % 3 == 0);
    endcase
  end

  // Offer one request and hold it until the formatter takes it. At the start
  // of each burst the sender may first go quiet; such a gap is never empty, so
  // valid never drops and rises in the same step.
  task automatic drive_req(input logic [CharW-1:0] ch, input logic [ArgFieldW-1:0] arg);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_req_i   <= '{fmt_char: ch, arg_value: arg};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    n_sent++;
  endtask

  // A conversion is a '%' request followed by the conversion character. The
  // argument on the '%' itself is ignored by the formatter, so it is random.
  task automatic drive_conv(input logic [CharW-1:0] conv, input logic [ArgFieldW-1:0] arg);
    drive_req(ChPercent, ArgFieldW'($urandom));
    drive_req(conv, arg);
  endtask

  // Stop sending and wait until every predicted character has been seen.
  // The pending count is read on the falling edge, away from the checker's
  // update at the rising edge.
  task automatic drain_outputs();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
    burst_left = 0;
  endtask

  // Arguments lean toward the digit-count boundaries of both bases, where
  // leading-zero suppression and the digit loop are most likely to slip.
  function automatic logic [ArgFieldW-1:0] pick_arg();
    logic [ArgFieldW-1:0] edges[12];
    edges = '{16'd0, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999, 16'd1000,
              16'd9999, 16'd10000, 16'h000F, 16'h0FFF, 16'hFFFF};
    case ($urandom_range(0, 4))
      0: return ArgFieldW'($urandom_range(0, 15));
      1: return ArgFieldW'($urandom_range(0, 255));
      2: return edges[$urandom_range(0, 11)] + ArgFieldW'($urandom_range(0, 1));
      default: return ArgFieldW'($urandom);
    endcase
  endfunction

  function automatic logic [CharW-1:0] pick_conv();
    case ($urandom_range(0, 2))
      0: return ChConvC;
      1: return ChConvD;
      default: return ChConvX;
    endcase
  endfunction

  initial begin
    int               counted;
    int               pick;
    bit               drained;
    logic [CharW-1:0] ch;

    counted = 0;
    drained = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: character extremes, every conversion at both ends of the
    // argument range, and the malformed sequences.
    drive_req(8'h48, 16'h0000);
    drive_req(8'h00, 16'hFFFF);          // a zero byte is echoed, not a terminator
    drive_req(8'hFF, 16'h0000);
    drive_conv(ChConvC, 16'hFFFF);
    drive_conv(ChConvC, 16'h1200);       // only the low byte goes out
    drive_conv(ChConvD, 16'h0000);
    drive_conv(ChConvD, 16'hFFFF);
    drive_conv(ChConvX, 16'h0000);
    drive_conv(ChConvX, 16'hFFFF);
    drive_conv(ChConvX, 16'h0A0B);
    drive_conv(ChPercent, 16'h1234);     // doubled percent prints nothing
    drive_req(ChConvD, 16'h0000);        // so this 'd' is an ordinary character
    drive_conv(8'h71, 16'h5555);         // unknown conversion letter
    drive_conv(8'h00, 16'hAAAA);
    n_plain = 4;
    n_conv  = 7;
    n_noise = 3;

    // Give the formatter a quiet moment with everything delivered.
    drain_outputs();

    // Random part: mostly ordinary text and well-formed conversions with
    // random arguments, plus some malformed percent sequences.
    while (counted < RandomItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        ch = CharW'($urandom_range(0, 255));
        if (ch == ChPercent) begin
          ch = ch ^ 8'h01;
        end
        drive_req(ch, ArgFieldW'($urandom));
        n_plain++;
        counted += 1;
      end else if (pick < 85) begin
        drive_conv(pick_conv(), pick_arg());
        n_conv++;
        counted += 2;
      end else begin
        ch = ($urandom_range(0, 2) == 0) ? ChPercent : CharW'($urandom_range(0, 255));
        drive_conv(ch, ArgFieldW'($urandom));
        n_noise++;
        counted += 2;
      end
      if (!drained && counted >= RandomItems / 2) begin
        drain_outputs();
        drained = 1'b1;
      end
    end

    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (TailCycles) @(posedge clk_i);

    $display("Summary: %0d requests sent: %0d plain characters, %0d conversions, %0d malformed.",
             n_sent, n_plain, n_conv, n_noise);
    $display("Summary: %0d output characters checked against the prediction.", checked);
    if (mismatches == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding.", cycles, pending);
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/nfmt_pkg.sv
rtl/nfmt_dabble.sv
rtl/nfmt_emit.sv
rtl/format_string_number_formatter_top.sv
tb/format_string_number_formatter_checker.sv
tb/format_string_number_formatter_top_test.sv
